// ----- hdl/bmp24_stream_parser_macros.svh -----
// Assertion macros for the BMP stream parser port checker.
`ifndef BMP24_STREAM_PARSER_MACROS_SVH
`define BMP24_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/bmp_pkg.sv -----
// Types and result codes shared by the BMP stream parser.
`timescale 1ns / 1ps

package bmp_pkg;

  // Width of position and size fields on the result channel
  localparam int unsigned FieldW = 17;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_FORMAT = 2'd2;
  localparam logic [1:0] KIND_TRUNC  = 2'd3;

  // One input byte with its framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_stream;
  } item_t;

  // One result
  typedef struct packed {
    logic [1:0]        result_kind;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [FieldW-1:0] column;
    logic [FieldW-1:0] row;
    logic [FieldW-1:0] image_width;
    logic [FieldW-1:0] image_height;
    logic              last_pixel;
  } res_t;

endpackage

// ----- hdl/bmp_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps

interface bmp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/bmp24_stream_parser.sv -----
// Top level of the 24-bit BMP stream parser: input register, decode, result register.
//
//   channel | dir | payload           | transfer
//   in_i    | in  | bmp_pkg::item_t   | in_i.valid && in_i.ready
//   out_o   | out | bmp_pkg::res_t    | out_o.valid && out_o.ready
//
// One byte per cycle sustained while the result side is ready; a byte's result is
// loaded into the result register once the decode stage advances on it.
// Reset clears the parser state and both valid flags; no clearing pass.
// A stalled result holds the decode stage; an empty input register still takes
// one more byte, after which the input side waits for the result transfer.
`timescale 1ns / 1ps

module bmp24_stream_parser #(
  parameter int unsigned DIM_LIMIT = 100000
) (
  input logic          clk_i,
  input logic          rst_ni,
  bmp_stream_if.sink   in_i,
  bmp_stream_if.source out_o
);
  import bmp_pkg::*;

  logic  in_valid_q;
  item_t in_item_q;
  logic  out_valid_q;
  res_t  out_res_q;
  logic  advance;
  logic  res_valid;
  res_t  res;

  // Decode stage moves when the result slot is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.data;
    end
  end

  bmp_core #(
    .DIM_LIMIT(DIM_LIMIT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (advance),
    .item_i     (in_item_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_res_q;

endmodule

// ----- hdl/bmp_core.sv -----
// Parser state and per-byte decode: header fields, pixel assembly, padding.
`timescale 1ns / 1ps

module bmp_core #(
  parameter int unsigned DIM_LIMIT = 100000
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  bmp_pkg::item_t item_i,
  output logic           res_valid_o,
  output bmp_pkg::res_t  res_o
);
  import bmp_pkg::*;

  localparam int unsigned DimW = $clog2(DIM_LIMIT + 1);

  // Header byte offsets
  localparam logic [5:0] PosMagic0 = 6'd0;
  localparam logic [5:0] PosMagic1 = 6'd1;
  localparam logic [5:0] PosWidth  = 6'd18;
  localparam logic [5:0] PosHeight = 6'd22;
  localparam logic [5:0] PosDepth  = 6'd28;
  localparam logic [5:0] HdrLast   = 6'd53;

  localparam logic [7:0]  MagicB = 8'h42;
  localparam logic [7:0]  MagicM = 8'h4D;
  localparam logic [15:0] Bpp24  = 16'd24;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PIXEL  = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [5:0]      hdr_pos;
    logic            magic_ok;
    logic [31:0]     width_w;
    logic [31:0]     height_w;
    logic [15:0]     depth_w;
    logic [DimW-1:0] col;
    logic [DimW-1:0] row;
    logic [1:0]      bip;
    logic [1:0]      pad;
    logic [7:0]      held_blue;
    logic [7:0]      held_green;
  } state_t;

  // Cleared parser state: header phase, everything else zero
  localparam state_t StReset = '{phase: PH_HEADER, default: '0};

  state_t        st_q, st_d, cur;
  logic [7:0]    b;
  logic [DimW:0] col_inc, row_inc, w_ext, h_ext;
  logic          col_end, row_end, hdr_ok;
  logic [1:0]    pad_dec;

  // Size check on a signed 32-bit header word
  function automatic logic dim_ok(logic [31:0] v);
    return !v[31] && (v != '0) && (v <= 32'(DIM_LIMIT));
  endfunction

  // Next state and result for the byte in the input register
  always_comb begin
    cur       = item_i.start_of_file ? StReset : st_q;
    st_d      = cur;
    b         = item_i.data_byte;
    res_o     = '0;
    res_valid_o = 1'b0;

    col_inc = {1'b0, cur.col} + 1'b1;
    row_inc = {1'b0, cur.row} + 1'b1;
    w_ext   = cur.width_w[DimW:0];
    h_ext   = cur.height_w[DimW:0];
    col_end = (col_inc >= w_ext);
    row_end = (row_inc >= h_ext);
    hdr_ok  = cur.magic_ok && dim_ok(cur.width_w) && dim_ok(cur.height_w)
              && (cur.depth_w == Bpp24);
    pad_dec = cur.pad - 2'd1;

    unique case (cur.phase)
      PH_HEADER: begin
        case (cur.hdr_pos)
          PosMagic0:          st_d.magic_ok = (b == MagicB);
          PosMagic1:          st_d.magic_ok = cur.magic_ok && (b == MagicM);
          PosWidth:           st_d.width_w[7:0]    = b;
          PosWidth + 6'd1:    st_d.width_w[15:8]   = b;
          PosWidth + 6'd2:    st_d.width_w[23:16]  = b;
          PosWidth + 6'd3:    st_d.width_w[31:24]  = b;
          PosHeight:          st_d.height_w[7:0]   = b;
          PosHeight + 6'd1:   st_d.height_w[15:8]  = b;
          PosHeight + 6'd2:   st_d.height_w[23:16] = b;
          PosHeight + 6'd3:   st_d.height_w[31:24] = b;
          PosDepth:           st_d.depth_w[7:0]    = b;
          PosDepth + 6'd1:    st_d.depth_w[15:8]   = b;
          default: ;
        endcase
        if (cur.hdr_pos >= HdrLast) begin
          res_valid_o = 1'b1;
          if (hdr_ok) begin
            res_o.result_kind  = KIND_HEADER;
            res_o.image_width  = cur.width_w[FieldW-1:0];
            res_o.image_height = cur.height_w[FieldW-1:0];
            st_d.phase         = PH_PIXEL;
          end else begin
            res_o.result_kind = KIND_FORMAT;
            st_d.phase        = PH_DONE;
          end
        end else begin
          st_d.hdr_pos = cur.hdr_pos + 6'd1;
        end
      end
      PH_PIXEL: begin
        case (cur.bip)
          2'd0: begin
            st_d.held_blue = b;
            st_d.bip       = 2'd1;
          end
          2'd1: begin
            st_d.held_green = b;
            st_d.bip        = 2'd2;
          end
          default: begin
            // third byte of the triple completes a pixel
            st_d.bip           = 2'd0;
            res_valid_o        = 1'b1;
            res_o.result_kind  = KIND_PIXEL;
            res_o.red          = b;
            res_o.green        = cur.held_green;
            res_o.blue         = cur.held_blue;
            res_o.column       = FieldW'(cur.col);
            res_o.row          = FieldW'(cur.row);
            res_o.last_pixel   = col_end && row_end;
            st_d.col           = col_inc[DimW-1:0];
            if (col_end) begin
              st_d.pad = cur.width_w[1:0];
              if (cur.width_w[1:0] != 2'd0) begin
                st_d.phase = PH_PAD;
              end else begin
                st_d.col   = '0;
                st_d.row   = row_inc[DimW-1:0];
                st_d.phase = row_end ? PH_DONE : PH_PIXEL;
              end
            end
          end
        endcase
      end
      PH_PAD: begin
        // drop padding, then move to the next row
        st_d.pad = pad_dec;
        if (pad_dec == 2'd0) begin
          st_d.col   = '0;
          st_d.row   = row_inc[DimW-1:0];
          st_d.phase = row_end ? PH_DONE : PH_PIXEL;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // Early end of stream before the parse is done overrides a pixel or header-accepted result
    if (item_i.end_of_stream && (cur.phase != PH_DONE) && (st_d.phase != PH_DONE)) begin
      res_o             = '0;
      res_o.result_kind = KIND_TRUNC;
      res_valid_o       = 1'b1;
      st_d.phase        = PH_DONE;
    end
  end

  // State register, updated once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StReset;
    end else if (take_i) begin
      st_q <= st_d;
    end
  end

endmodule

// ----- hdl/bmp_checker.sv -----
// Port-level checks on the result channel of the BMP stream parser.
`timescale 1ns / 1ps
`include "bmp24_stream_parser_macros.svh"

module bmp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input bmp_pkg::res_t out_data_i
);
  import bmp_pkg::*;

  // A stalled result keeps its payload
  `BMP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, $stable(out_data_i), "result changed while stalled")

  // Only pixels carry color and position
  `BMP_ASSERT_IMP(a_nonpix_zero, out_valid_i && (out_data_i.result_kind != KIND_PIXEL), (out_data_i.red == '0) && (out_data_i.green == '0) && (out_data_i.blue == '0) && (out_data_i.column == '0) && (out_data_i.row == '0), "non-pixel result has pixel fields")

  // Only the header-accepted result carries the image size
  `BMP_ASSERT_IMP(a_size_hdr_only, out_valid_i && (out_data_i.result_kind != KIND_HEADER), (out_data_i.image_width == '0) && (out_data_i.image_height == '0), "size given outside header result")

  // Last-pixel flag appears only on pixels
  `BMP_ASSERT_IMP(a_last_is_pix, out_valid_i && out_data_i.last_pixel, out_data_i.result_kind == KIND_PIXEL, "last flag on non-pixel result")

endmodule

bind bmp24_stream_parser bmp_checker u_bmp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

// ----- tb/sv/bmp24_stream_parser_checker.sv -----
// Scoreboard for the BMP stream parser: watches both channels, predicts results, compares.
`timescale 1ns / 1ps

module bmp24_stream_parser_checker #(
  parameter int unsigned DIM_LIMIT = 100000
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           byte_valid_i,
  input  logic           byte_ready_i,
  input  bmp_pkg::item_t byte_i,
  input  logic           res_valid_i,
  input  logic           res_ready_i,
  input  bmp_pkg::res_t  res_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import bmp_pkg::*;

  localparam logic [7:0]  MAGIC_B  = 8'h42;  // 'B'
  localparam logic [7:0]  MAGIC_M  = 8'h4D;  // 'M'
  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam int unsigned REPORT_MAX = 10;

  typedef enum logic [1:0] {ST_HEADER, ST_PIXEL, ST_PAD, ST_DONE} parse_phase_e;

  // Parser state mirrored from the byte stream
  parse_phase_e phase = ST_HEADER;
  logic [5:0]   hdr_pos = '0;
  logic         magic_ok = 1'b0;
  logic [31:0]  width_word = '0;
  logic [31:0]  height_word = '0;
  logic [15:0]  depth_word = '0;
  logic [31:0]  col_cnt = '0;
  logic [31:0]  row_cnt = '0;
  logic [1:0]   pix_byte = '0;
  logic [1:0]   pad_left = '0;
  logic [7:0]   held_blue = '0;
  logic [7:0]   held_green = '0;

  res_t        decoded_q[$];
  int unsigned fails = 0;

  function automatic void clear_state();
    phase       = ST_HEADER;
    hdr_pos     = '0;
    magic_ok    = 1'b0;
    width_word  = '0;
    height_word = '0;
    depth_word  = '0;
    col_cnt     = '0;
    row_cnt     = '0;
    pix_byte    = '0;
    pad_left    = '0;
    held_blue   = '0;
    held_green  = '0;
  endfunction

  // Signed 32-bit value in 1..DIM_LIMIT
  function automatic bit dim_in_range(input logic [31:0] v);
    return !v[31] && v >= 32'd1 && v <= 32'(DIM_LIMIT);
  endfunction

  // Row done (pixels and padding): next row or image complete
  function automatic void next_row();
    col_cnt = '0;
    row_cnt = row_cnt + 32'd1;
    phase   = (row_cnt >= height_word) ? ST_DONE : ST_PIXEL;
  endfunction

  // Advance the parser by one byte and queue the result it causes, if any
  function automatic void decode_byte(input item_t it);
    res_t         r;
    bit           have;
    parse_phase_e entry;
    r    = '0;
    have = 1'b0;
    if (it.start_of_file) clear_state();
    entry = phase;
    case (phase)
      ST_HEADER: begin
        if (hdr_pos == 6'd0) begin
          magic_ok = (it.data_byte == MAGIC_B);
        end else if (hdr_pos == 6'd1) begin
          magic_ok = magic_ok && (it.data_byte == MAGIC_M);
        end else if (hdr_pos >= 6'd18 && hdr_pos <= 6'd21) begin
          width_word |= 32'(it.data_byte) << (8 * (hdr_pos - 6'd18));
        end else if (hdr_pos >= 6'd22 && hdr_pos <= 6'd25) begin
          height_word |= 32'(it.data_byte) << (8 * (hdr_pos - 6'd22));
        end else if (hdr_pos == 6'd28 || hdr_pos == 6'd29) begin
          depth_word |= 16'(it.data_byte) << (8 * (hdr_pos - 6'd28));
        end
        if (hdr_pos >= 6'd53) begin
          have = 1'b1;
          if (magic_ok && dim_in_range(width_word) && dim_in_range(height_word) &&
              depth_word == DEPTH_24) begin
            r.result_kind  = KIND_HEADER;
            r.image_width  = width_word[FieldW-1:0];
            r.image_height = height_word[FieldW-1:0];
            phase          = ST_PIXEL;
          end else begin
            r.result_kind = KIND_FORMAT;
            phase         = ST_DONE;
          end
        end else begin
          hdr_pos = hdr_pos + 6'd1;
        end
      end
      ST_PIXEL: begin
        if (pix_byte == 2'd0) begin
          held_blue = it.data_byte;
          pix_byte  = 2'd1;
        end else if (pix_byte == 2'd1) begin
          held_green = it.data_byte;
          pix_byte   = 2'd2;
        end else begin
          pix_byte      = 2'd0;
          have          = 1'b1;
          r.result_kind = KIND_PIXEL;
          r.red         = it.data_byte;
          r.green       = held_green;
          r.blue        = held_blue;
          r.column      = col_cnt[FieldW-1:0];
          r.row         = row_cnt[FieldW-1:0];
          r.last_pixel  = (col_cnt + 32'd1 >= width_word) &&
                          (row_cnt + 32'd1 >= height_word);
          col_cnt = col_cnt + 32'd1;
          if (col_cnt >= width_word) begin
            pad_left = width_word[1:0];
            if (pad_left != 2'd0) phase = ST_PAD;
            else next_row();
          end
        end
      end
      ST_PAD: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) next_row();
      end
      default: ;
    endcase
    // Stream ends before the image is complete: truncation replaces a pixel or header-accepted result
    if (it.end_of_stream && entry != ST_DONE && phase != ST_DONE) begin
      r             = '0;
      r.result_kind = KIND_TRUNC;
      have          = 1'b1;
      phase         = ST_DONE;
    end
    if (have) decoded_q.push_back(r);
  endfunction

  // Compare one result transfer against the oldest prediction
  function automatic void check_result(input res_t got);
    res_t want;
    if (decoded_q.size() == 0) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("%0t: unexpected result kind %0d col %0d row %0d", $realtime,
                 got.result_kind, got.column, got.row);
      return;
    end
    want = decoded_q.pop_front();
    if (got.result_kind !== want.result_kind || got.red !== want.red ||
        got.green !== want.green || got.blue !== want.blue ||
        got.column !== want.column || got.row !== want.row ||
        got.image_width !== want.image_width || got.image_height !== want.image_height ||
        got.last_pixel !== want.last_pixel) begin
      fails++;
      if (fails <= REPORT_MAX) begin
        $display("%0t: result mismatch (expected / actual)", $realtime);
        $display("  kind %0d / %0d  rgb %h%h%h / %h%h%h  last %0b / %0b",
                 want.result_kind, got.result_kind, want.red, want.green, want.blue,
                 got.red, got.green, got.blue, want.last_pixel, got.last_pixel);
        $display("  col %0d / %0d  row %0d / %0d  size %0dx%0d / %0dx%0d",
                 want.column, got.column, want.row, got.row, want.image_width,
                 want.image_height, got.image_width, got.image_height);
      end
    end
  endfunction

  // Results are checked before the byte of the same edge is decoded: a result
  // leaves the block no earlier than the edge after its byte's transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      decoded_q.delete();
    end else begin
      if (res_valid_i && res_ready_i) check_result(res_i);
      if (byte_valid_i && byte_ready_i) decode_byte(byte_i);
    end
    fail_count_o <= fails;
    pending_o    <= decoded_q.size();
  end

endmodule

// ----- tb/sv/bmp24_stream_parser_tb.sv -----
// Top of the BMP stream parser testbench: clock, reset, byte stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module bmp24_stream_parser_tb;
  import bmp_pkg::*;

  localparam int unsigned DimLimit     = 100000;
  localparam int unsigned RandomBytes  = 600;
  localparam int unsigned SettleCycles = 50;
  localparam logic [7:0]  MAGIC_B      = 8'h42;  // 'B'
  localparam logic [7:0]  MAGIC_M      = 8'h4D;  // 'M'
  localparam logic [15:0] DEPTH_24     = 16'd24;

  typedef enum int {MAGIC_GOOD, MAGIC_BAD_B, MAGIC_BAD_M} magic_fault_e;
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bmp_stream_if #(.T(item_t)) byte_ch ();
  bmp_stream_if #(.T(res_t))  res_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;

  rx_mode_e    rx_mode  = RX_OPEN;
  int unsigned rx_cycle = 0;
  int unsigned rx_hold  = 0;
  logic        rx_level = 1'b1;

  bmp24_stream_parser #(.DIM_LIMIT(DimLimit)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (res_ch)
  );

  bmp24_stream_parser_checker #(.DIM_LIMIT(DimLimit)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_ch.valid),
    .byte_ready_i (byte_ch.ready),
    .byte_i       (byte_ch.data),
    .res_valid_i  (res_ch.valid),
    .res_ready_i  (res_ch.ready),
    .res_i        (res_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side stalls in one of four patterns, picked anew at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 300 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:     res_ch.ready <= 1'b1;
        RX_RANDOM:   res_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: res_ch.ready <= (rx_cycle % 7 >= 3);
        default: begin
          if (rx_hold == 0) begin
            rx_level = ~rx_level;
            rx_hold  = $urandom_range(1, 20);
          end else begin
            rx_hold--;
          end
          res_ch.ready <= rx_level;
        end
      endcase
    end
  end

  // Byte values lean toward the extremes
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // One byte transfer; the sender runs in bursts with idle gaps between them
  task automatic push_byte(input item_t it);
    if (burst_left == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data  <= it;
    do @(posedge clk_i); while (!byte_ch.ready);
    burst_left--;
    bytes_sent++;
  endtask

  // Hold the sender until every predicted result has arrived
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Send a file: 54-byte header plus pixel rows. A cut index stops the file early;
  // the last byte sent carries end_of_stream when stop is set; tail bytes follow.
  task automatic send_file(input logic [31:0] w_word, input logic [31:0] h_word,
                           input logic [15:0] bpp, input magic_fault_e magic,
                           input int cut, input bit stop, input int tail);
    int         body;
    int         last;
    logic [7:0] b;
    item_t      it;
    if (w_word >= 1 && w_word <= 64 && h_word >= 1 && h_word <= 64)
      body = int'(h_word) * (3 * int'(w_word) + int'(w_word[1:0]));
    else
      body = 90;  // out-of-range or large sizes: only 90 bytes of pixel data
    last = (cut >= 0 && cut < 54 + body) ? cut : 53 + body;
    for (int p = 0; p <= last; p++) begin
      b = rand_byte();
      if (p == 0) begin
        b = MAGIC_B;
        if (magic == MAGIC_BAD_B) while (b == MAGIC_B) b = 8'($urandom);
      end else if (p == 1) begin
        b = MAGIC_M;
        if (magic == MAGIC_BAD_M) while (b == MAGIC_M) b = 8'($urandom);
      end else if (p >= 18 && p <= 21) begin
        b = w_word[8 * (p - 18) +: 8];
      end else if (p >= 22 && p <= 25) begin
        b = h_word[8 * (p - 22) +: 8];
      end else if (p == 28 || p == 29) begin
        b = bpp[8 * (p - 28) +: 8];
      end
      it.data_byte     = b;
      it.start_of_file = (p == 0);
      it.end_of_stream = stop && (p == last);
      push_byte(it);
    end
    repeat (tail) begin
      it.data_byte     = rand_byte();
      it.start_of_file = 1'b0;
      it.end_of_stream = ($urandom_range(0, 3) == 0);
      push_byte(it);
    end
  endtask

  // Random images, mostly well formed; some cut short, some with broken headers, some large, some noise
  task automatic random_file();
    logic [31:0] w;
    logic [31:0] h;
    logic [15:0] bpp;
    int          sel;
    int          total;
    item_t       it;
    w   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
    h   = $urandom_range(1, 4);
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      send_file(w, h, DEPTH_24, MAGIC_GOOD, -1, $urandom_range(0, 1),
                ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
    end else if (sel < 72) begin
      total = 54 + int'(h) * (3 * int'(w) + int'(w[1:0]));
      send_file(w, h, DEPTH_24, MAGIC_GOOD, $urandom_range(0, total - 1),
                $urandom_range(0, 4) != 0, 0);
    end else if (sel < 85) begin
      bpp = DEPTH_24;
      case ($urandom_range(0, 6))
        0: send_file(w, h, bpp, MAGIC_BAD_B, 53, 0, 0);
        1: send_file(w, h, bpp, MAGIC_BAD_M, 53, 0, 0);
        2: begin
          while (bpp == DEPTH_24) bpp = 16'($urandom);
          send_file(w, h, bpp, MAGIC_GOOD, 53, 0, 0);
        end
        3: send_file(0, h, bpp, MAGIC_GOOD, 53, $urandom_range(0, 1), 0);
        4: send_file($urandom_range(DimLimit + 1, 2 * DimLimit), h, bpp, MAGIC_GOOD,
                     53 + $urandom_range(0, 2), 0, 0);
        5: send_file(w, $urandom | 32'h8000_0000, bpp, MAGIC_GOOD, 53, 0, 0);
        default: send_file($urandom, $urandom, bpp, MAGIC_GOOD, 53, 0, 0);
      endcase
    end else if (sel < 92) begin
      if ($urandom_range(0, 1) == 0)
        send_file($urandom_range(1000, DimLimit), $urandom_range(1, DimLimit), DEPTH_24,
                  MAGIC_GOOD, -1, $urandom_range(0, 1), 0);
      else
        send_file($urandom_range(1, 5), $urandom_range(1000, DimLimit), DEPTH_24,
                  MAGIC_GOOD, -1, $urandom_range(0, 1), 0);
    end else begin
      // Noise: random bytes with random framing flags
      repeat ($urandom_range(1, 12)) begin
        it.data_byte     = 8'($urandom);
        it.start_of_file = ($urandom_range(0, 7) == 0);
        it.end_of_stream = ($urandom_range(0, 7) == 0);
        push_byte(it);
      end
    end
  endtask

  initial begin
    int unsigned rand_start;
    item_t       it;
    byte_ch.valid = 1'b0;
    byte_ch.data  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest image with stop on its last byte, then ignored trailing bytes
    send_file(1, 1, DEPTH_24, MAGIC_GOOD, -1, 1, 2);
    // Row length already a multiple of four, and three pad bytes per row
    send_file(4, 2, DEPTH_24, MAGIC_GOOD, -1, 0, 0);
    send_file(3, 3, DEPTH_24, MAGIC_GOOD, -1, 0, 1);
    // Truncation inside the row padding
    send_file(2, 2, DEPTH_24, MAGIC_GOOD, 60, 1, 0);
    // Largest size accepted; truncation replaces the first pixel
    send_file(DimLimit, DimLimit, DEPTH_24, MAGIC_GOOD, 56, 1, 0);
    // Truncation replaces header accepted; format error wins over truncation
    send_file(5, 1, DEPTH_24, MAGIC_GOOD, 53, 1, 0);
    send_file(0, 1, DEPTH_24, MAGIC_GOOD, 53, 1, 0);
    // Size out of range: above the limit, zero height, negative values
    send_file(DimLimit + 1, 1, DEPTH_24, MAGIC_GOOD, 55, 0, 0);
    send_file(1, 0, DEPTH_24, MAGIC_GOOD, 53, 0, 0);
    send_file(32'h8000_0001, 1, DEPTH_24, MAGIC_GOOD, 53, 0, 0);
    send_file(1, 32'hFFFF_FFFF, DEPTH_24, MAGIC_GOOD, 53, 0, 0);
    // Wrong depth, including 24 in the low byte only
    send_file(1, 1, 16'd32, MAGIC_GOOD, 53, 0, 0);
    send_file(1, 1, 16'h0118, MAGIC_GOOD, 53, 0, 0);
    // Bad magic in either byte is only reported at the header end
    send_file(2, 2, DEPTH_24, MAGIC_BAD_B, 54, 0, 0);
    send_file(2, 2, DEPTH_24, MAGIC_BAD_M, 53, 0, 0);
    // Early end inside the header; restart by a new file mid-image
    send_file(2, 1, DEPTH_24, MAGIC_GOOD, 20, 1, 0);
    send_file(3, 2, DEPTH_24, MAGIC_GOOD, 62, 0, 0);
    // A file that is one byte long: start and end on the same byte
    it = '{data_byte: 8'hFF, start_of_file: 1'b1, end_of_stream: 1'b1};
    push_byte(it);
    send_file(1, 2, DEPTH_24, MAGIC_GOOD, -1, 0, 0);
    wait_drained();

    // Random part
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RandomBytes) begin
      random_file();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
